>>> src/resource_grant_with_wait_list_assert.svh
// Assertion macros shared by the resource grant RTL.
// Each macro checks a property on the rising edge of clk and is switched off
// while the active-low reset is asserted.
`ifndef RESOURCE_GRANT_WITH_WAIT_LIST_ASSERT_SVH
`define RESOURCE_GRANT_WITH_WAIT_LIST_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define RGWL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("resource grant assertion failed");

// Next-cycle implication.
`define RGWL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("resource grant assertion failed");

`else

`define RGWL_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define RGWL_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> src/rgwl_pkg.sv
package rgwl_pkg;

    // Field widths of the request and result channels.
    localparam int OP_W        = 1;
    localparam int CLIENT_ID_W = 4;
    localparam int STATUS_W    = 3;
    localparam int RES_FIELD_W = 2;

    // Configuration and counter widths.
    localparam int ACTIVE_W   = 5;
    localparam int WAIT_CNT_W = 5;

    localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET = 5'd16;
    localparam logic [WAIT_CNT_W-1:0] WAIT_CNT_MAX = '1;

    // Defaults for the top-level parameters.
    localparam int MAX_CLIENTS_DEF   = 16;
    localparam int NUM_RESOURCES_DEF = 4;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        PH_TO_ARRIVE = 2'd0,
        PH_WAIT      = 2'd1,
        PH_HOLD      = 2'd2,
        PH_DONE      = 2'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANT  = 3'd0,
        ST_WAIT   = 3'd1,
        ST_HANDED = 3'd2,
        ST_IDLE   = 3'd3,
        ST_ERROR  = 3'd4
    } status_t;

endpackage

>>> src/rgwl_if.sv
// Request channel: one request or release from a client.
interface rgwl_req_if;
    logic                              valid;
    logic                              ready;
    logic [rgwl_pkg::OP_W-1:0]         op;
    logic [rgwl_pkg::CLIENT_ID_W-1:0]  client_id;

    modport source (output valid, output op, output client_id, input ready);
    modport sink   (input valid, input op, input client_id, output ready);
endinterface

// Result channel: the outcome of one request.
interface rgwl_res_if;
    logic                              valid;
    logic                              ready;
    logic [rgwl_pkg::STATUS_W-1:0]     status;
    logic [rgwl_pkg::CLIENT_ID_W-1:0]  grant_client;
    logic [rgwl_pkg::RES_FIELD_W-1:0]  grant_resource;
    logic [rgwl_pkg::RES_FIELD_W-1:0]  freed_resource;

    modport source (output valid, output status, output grant_client,
                    output grant_resource, output freed_resource, input ready);
    modport sink   (input valid, input status, input grant_client,
                    input grant_resource, input freed_resource, output ready);
endinterface

>>> src/resource_grant_with_wait_list.sv
// Fixed-priority allocator of NUM_RESOURCES shared resources among up to
// MAX_CLIENTS clients, with a wait list. Each request on the req channel is
// either a request for a resource (the client gets the lowest-numbered
// resource that no active client holds, or joins the wait list) or a release
// (the client's resource is freed and handed straight to the lowest-numbered
// active waiting client, if any). Every request yields exactly one result on
// the res channel; a request from an inactive client, a second request from
// the same client, or a release from a client holding nothing returns the
// error status and leaves the state untouched. The block takes one request
// per clock cycle unless the res channel backs up: a request is captured in
// an input register, decided by priority encoders over the per-client
// state, and its result is loaded into the result register when the
// decision stage advances. Only backpressure on the res channel slows
// acceptance. The active_clients register (cfg_wr_en, cfg_wr_data) sets how
// many clients take part; the user must write it only while the block is
// idle, as the block does not enforce this. Reset clears the phases, the
// wait count and the valid flags at once; there is no clearing pass.
`include "resource_grant_with_wait_list_assert.svh"

module resource_grant_with_wait_list #(
    parameter int MAX_CLIENTS   = rgwl_pkg::MAX_CLIENTS_DEF,
    parameter int NUM_RESOURCES = rgwl_pkg::NUM_RESOURCES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rgwl_pkg::ACTIVE_W-1:0] cfg_wr_data,
    rgwl_req_if.sink                      req,
    rgwl_res_if.source                    res
);
    import rgwl_pkg::*;

    // Widths derived from the parameters. The client index addresses the
    // per-client state; the resource number is stored per holding client.
    localparam int CIDX_W    = $clog2(MAX_CLIENTS);
    localparam int RES_W     = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int CID_EXT_W = (CIDX_W > CLIENT_ID_W) ? CIDX_W : CLIENT_ID_W;
    localparam int RES_EXT_W = (RES_W > RES_FIELD_W) ? RES_W : RES_FIELD_W;

    // Configuration register.
    logic [ACTIVE_W-1:0] active_reg;

    // Input register stage.
    logic                   s1_valid_reg;
    op_t                    s1_op_reg;
    logic [CLIENT_ID_W-1:0] s1_id_reg;

    // Allocation state. A client holds a resource exactly when its phase is
    // PH_HOLD, so the held number needs no valid bit and no reset.
    phase_t [MAX_CLIENTS-1:0]            phase_reg;
    phase_t [MAX_CLIENTS-1:0]            phase_next;
    logic   [MAX_CLIENTS-1:0][RES_W-1:0] held_reg;
    logic   [MAX_CLIENTS-1:0][RES_W-1:0] held_next;
    logic   [WAIT_CNT_W-1:0]             wait_cnt_reg;
    logic   [WAIT_CNT_W-1:0]             wait_cnt_next;

    // Result register stage.
    logic                   out_valid_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [CLIENT_ID_W-1:0] grant_client_reg;
    logic [CLIENT_ID_W-1:0] grant_client_next;
    logic [RES_FIELD_W-1:0] grant_res_reg;
    logic [RES_FIELD_W-1:0] grant_res_next;
    logic [RES_FIELD_W-1:0] freed_res_reg;
    logic [RES_FIELD_W-1:0] freed_res_next;

    // Decision logic.
    logic                     advance;
    logic [MAX_CLIENTS-1:0]   active_mask;
    logic [NUM_RESOURCES-1:0] taken;
    logic                     free_found;
    logic [RES_W-1:0]         free_res;
    logic                     waiter_found;
    logic [CIDX_W-1:0]        waiter_idx;
    logic [CID_EXT_W-1:0]     id_ext;
    logic [CIDX_W-1:0]        id_idx;
    logic                     id_ok;
    phase_t                   cur_phase;
    logic [RES_W-1:0]         cur_held;
    logic [CIDX_W-1:0]        grant_idx;
    logic [CID_EXT_W-1:0]     waiter_ext;
    logic [RES_EXT_W-1:0]     free_res_ext;
    logic [RES_EXT_W-1:0]     cur_held_ext;

    // The decision stage moves whenever it holds a request and the result
    // register is empty or being drained this cycle.
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || advance;

    assign res.valid          = out_valid_reg;
    assign res.status         = status_reg;
    assign res.grant_client   = grant_client_reg;
    assign res.grant_resource = grant_res_reg;
    assign res.freed_resource = freed_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_reg <= cfg_wr_data;
        end
    end

    // A client takes part if its number is below active_clients. Client zero
    // always takes part, even when the limit is written as zero.
    always_comb
    begin
        for (int c = 0; c < MAX_CLIENTS; c++)
        begin
            active_mask[c] = (c == 0) || (c < 32'(active_reg));
        end
    end

    // The requesting client's index; it is only used once the number has been
    // checked against the client count.
    assign id_ext    = CID_EXT_W'(s1_id_reg);
    assign id_idx    = id_ext[CIDX_W-1:0];
    assign id_ok     = (32'(s1_id_reg) < MAX_CLIENTS) &&
                       ((s1_id_reg == '0) || (ACTIVE_W'(s1_id_reg) < active_reg));
    assign cur_phase = phase_reg[id_idx];
    assign cur_held  = held_reg[id_idx];

    // A resource is taken when some active client holds it.
    always_comb
    begin
        for (int r = 0; r < NUM_RESOURCES; r++)
        begin
            taken[r] = 1'b0;
            for (int c = 0; c < MAX_CLIENTS; c++)
            begin
                if (active_mask[c] && phase_reg[c] == PH_HOLD &&
                    held_reg[c] == RES_W'(r))
                begin
                    taken[r] = 1'b1;
                end
            end
        end
    end

    // Lowest-numbered free resource.
    always_comb
    begin
        free_found = 1'b0;
        free_res   = '0;
        for (int r = NUM_RESOURCES - 1; r >= 0; r--)
        begin
            if (!taken[r])
            begin
                free_found = 1'b1;
                free_res   = RES_W'(r);
            end
        end
    end

    // Lowest-numbered active waiting client. The wait counter gates the
    // search: once it reads zero, nobody is handed a resource.
    always_comb
    begin
        waiter_found = 1'b0;
        waiter_idx   = '0;
        for (int c = MAX_CLIENTS - 1; c >= 0; c--)
        begin
            if (active_mask[c] && phase_reg[c] == PH_WAIT && wait_cnt_reg != '0)
            begin
                waiter_found = 1'b1;
                waiter_idx   = CIDX_W'(c);
            end
        end
    end

    assign waiter_ext   = CID_EXT_W'(waiter_idx);
    assign free_res_ext = RES_EXT_W'(free_res);
    assign cur_held_ext = RES_EXT_W'(cur_held);

    // The client that ends up holding a resource: the requester on a grant,
    // the chosen waiter on a hand-on.
    assign grant_idx = (s1_op_reg == OP_REQUEST) ? id_idx : waiter_idx;

    // Decide the request and form the next state and the result.
    always_comb
    begin
        phase_next        = phase_reg;
        held_next         = held_reg;
        wait_cnt_next     = wait_cnt_reg;
        status_next       = ST_ERROR;
        grant_client_next = '0;
        grant_res_next    = '0;
        freed_res_next    = '0;
        if (id_ok)
        begin
            if (s1_op_reg == OP_REQUEST)
            begin
                if (cur_phase == PH_TO_ARRIVE)
                begin
                    if (free_found)
                    begin
                        phase_next[grant_idx] = PH_HOLD;
                        held_next[grant_idx]  = free_res;
                        status_next           = ST_GRANT;
                        grant_client_next     = s1_id_reg;
                        grant_res_next        = free_res_ext[RES_FIELD_W-1:0];
                    end
                    else
                    begin
                        phase_next[id_idx] = PH_WAIT;
                        if (wait_cnt_reg != WAIT_CNT_MAX)
                        begin
                            wait_cnt_next = wait_cnt_reg + WAIT_CNT_W'(1);
                        end
                        status_next = ST_WAIT;
                    end
                end
            end
            else if (cur_phase == PH_HOLD)
            begin
                // The releasing client is done; its resource goes to the
                // first waiter or stays idle.
                phase_next[id_idx] = PH_DONE;
                freed_res_next     = cur_held_ext[RES_FIELD_W-1:0];
                if (waiter_found)
                begin
                    phase_next[grant_idx] = PH_HOLD;
                    held_next[grant_idx]  = cur_held;
                    wait_cnt_next         = wait_cnt_reg - WAIT_CNT_W'(1);
                    status_next           = ST_HANDED;
                    grant_client_next     = waiter_ext[CLIENT_ID_W-1:0];
                    grant_res_next        = cur_held_ext[RES_FIELD_W-1:0];
                end
                else
                begin
                    status_next = ST_IDLE;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wait_cnt_reg  <= '0;
            phase_reg     <= '{default: PH_TO_ARRIVE};
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                wait_cnt_reg  <= wait_cnt_next;
                phase_reg     <= phase_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg <= op_t'(req.op);
            s1_id_reg <= req.client_id;
        end
        if (advance)
        begin
            held_reg         <= held_next;
            status_reg       <= status_next;
            grant_client_reg <= grant_client_next;
            grant_res_reg    <= grant_res_next;
            freed_res_reg    <= freed_res_next;
        end
    end

    // A hand-on always takes a client off a non-empty wait count.
    `RGWL_ASSERT_IMP(a_handed_count, clk, rst_n, advance && status_next == ST_HANDED, wait_cnt_reg != '0)

    // The client named in a grant or hand-on holds a resource afterwards.
    `RGWL_ASSERT_NXT(a_grant_holds, clk, rst_n, advance && (status_next == ST_GRANT || status_next == ST_HANDED), phase_reg[$past(grant_idx)] == PH_HOLD)

    // An error result leaves the allocation state untouched.
    `RGWL_ASSERT_NXT(a_error_keeps, clk, rst_n, advance && status_next == ST_ERROR, phase_reg == $past(phase_reg) && wait_cnt_reg == $past(wait_cnt_reg))

    // The decision stage only stalls behind a full, blocked result register.
    `RGWL_ASSERT_IMP(a_stall_cause, clk, rst_n, s1_valid_reg && !advance, out_valid_reg && !res.ready)

endmodule
